[src/arq_rly_pkg.sv]
// Shared types and constants for the two-port stop-and-wait relay.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package arq_rly_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_PORTS   = 2;
	localparam int TAG_W       = 16;
	localparam int THR_W       = 17;
	localparam int DRAW_W      = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W       = CNT_W + 1;
	localparam int ADDR_W      = 1 + PTR_W;
	localparam int MEM_DEPTH   = 2 ** ADDR_W;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);

	typedef enum logic [1:0] {
		CMD_LOCAL = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_ACK   = 2'd2,
		CMD_ERR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_ACK  = 2'd1,
		KIND_NAK  = 2'd2,
		KIND_DROP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_EMIT_A,
		ST_EMIT_B
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic decide;
		logic load_a;
		logic load_b;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic has_a;
		logic b_now;
		logic has_b;
		logic out_free;
	} ctl_sts_t;

	// circular pointer increment
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

[src/arq_rly_ifs.sv]
// Handshake channel interfaces of the relay: input item, result word, config write.
// Depends on arq_rly_pkg.
interface arq_rly_item_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    cmd;
	logic                          arrival_port;
	logic                          bit_error;
	logic [arq_rly_pkg::TAG_W-1:0] packet_tag;
	logic [arq_rly_pkg::DRAW_W-1:0] random_draw;
	logic [1:0]                    channel_busy;

	modport source (output valid, cmd, arrival_port, bit_error, packet_tag, random_draw,
		channel_busy, input ready);
	modport sink (input valid, cmd, arrival_port, bit_error, packet_tag, random_draw,
		channel_busy, output ready);
endinterface

interface arq_rly_result_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic                          port;
	logic [arq_rly_pkg::TAG_W-1:0] tag_out;
	logic                          last;

	modport source (output valid, kind, port, tag_out, last, input ready);
	modport sink (input valid, kind, port, tag_out, last, output ready);
endinterface

interface arq_rly_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [arq_rly_pkg::THR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[src/arq_rly_ctrl.sv]
// Sequencing state machine of the relay: capture, decide, then up to two result words.
// Depends on arq_rly_pkg.
module arq_rly_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  arq_rly_pkg::ctl_sts_t sts,
	output arq_rly_pkg::ctl_cmd_t cmd
);

	arq_rly_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arq_rly_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			arq_rly_pkg::ST_IDLE: begin
				if (item_valid) state_d = arq_rly_pkg::ST_DECIDE;
			end
			arq_rly_pkg::ST_DECIDE: begin
				if (sts.has_a) begin
					state_d = arq_rly_pkg::ST_EMIT_A;
				end else if (sts.b_now) begin
					state_d = arq_rly_pkg::ST_EMIT_B;
				end else begin
					state_d = arq_rly_pkg::ST_IDLE;
				end
			end
			arq_rly_pkg::ST_EMIT_A: begin
				if (sts.out_free) begin
					state_d = sts.has_b ? arq_rly_pkg::ST_EMIT_B : arq_rly_pkg::ST_IDLE;
				end
			end
			arq_rly_pkg::ST_EMIT_B: begin
				if (sts.out_free) state_d = arq_rly_pkg::ST_IDLE;
			end
			default: state_d = arq_rly_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready  = 1'b0;
		cmd         = '0;
		unique case (state_q)
			arq_rly_pkg::ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			arq_rly_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
			end
			arq_rly_pkg::ST_EMIT_A: begin
				cmd.load_a = sts.out_free;
			end
			arq_rly_pkg::ST_EMIT_B: begin
				cmd.load_b = sts.out_free;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

endmodule

[src/arq_rly_dp.sv]
// Relay datapath: item capture, route compare, per-port queue memory and pointers,
// result plan and the output word register. Depends on arq_rly_pkg and arq_rly_ifs.
module arq_rly_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  arq_rly_pkg::ctl_cmd_t            cmd,
	output arq_rly_pkg::ctl_sts_t            sts,
	input  logic [1:0]                       item_cmd,
	input  logic                             item_arrival_port,
	input  logic                             item_bit_error,
	input  logic [arq_rly_pkg::TAG_W-1:0]    item_packet_tag,
	input  logic [arq_rly_pkg::DRAW_W-1:0]   item_random_draw,
	input  logic [1:0]                       item_channel_busy,
	arq_rly_cfg_if.sink                      cfg,
	arq_rly_result_if.source                 result
);

	localparam int PTR_W  = arq_rly_pkg::PTR_W;
	localparam int CNT_W  = arq_rly_pkg::CNT_W;
	localparam int SUM_W  = arq_rly_pkg::SUM_W;
	localparam int TAG_W  = arq_rly_pkg::TAG_W;
	localparam int ADDR_W = arq_rly_pkg::ADDR_W;

	// captured item
	arq_rly_pkg::cmd_t                cmd_q;
	logic                             ap_q;
	logic                             berr_q;
	logic [TAG_W-1:0]                 tag_q;
	logic [arq_rly_pkg::DRAW_W-1:0]   draw_q;
	logic [1:0]                       busy_q;

	logic [arq_rly_pkg::THR_W-1:0]    thr_q;
	logic [PTR_W-1:0]                 head_q  [arq_rly_pkg::NUM_PORTS];
	logic [CNT_W-1:0]                 count_q [arq_rly_pkg::NUM_PORTS];

	logic [TAG_W-1:0]                 mem_q [arq_rly_pkg::MEM_DEPTH];
	logic [TAG_W-1:0]                 rd_data_q;

	// second-slot plan
	logic                             has_b_q;
	arq_rly_pkg::kind_t               b_kind_q;
	logic                             b_port_q;
	logic                             b_mem_q;

	logic                             out_valid_q;
	logic [1:0]                       out_kind_q;
	logic                             out_port_q;
	logic [TAG_W-1:0]                 out_tag_q;
	logic                             out_last_q;

	logic                             route_p;
	logic [CNT_W-1:0]                 r_cnt;
	logic                             r_full;
	logic [SUM_W-1:0]                 r_sum;
	logic [PTR_W-1:0]                 wr_ptr;
	logic [CNT_W-1:0]                 a_cnt;
	logic [PTR_W-1:0]                 a_next;
	logic [PTR_W-1:0]                 rd_ptr;
	logic                             is_route;
	logic                             has_a;
	logic                             b_now;
	arq_rly_pkg::kind_t               b_kind;
	logic                             b_port;
	logic                             b_mem;
	logic                             mem_we;
	logic                             out_free;

	assign cfg.ready = 1'b1;

	always_comb begin
		route_p  = ({1'b0, draw_q} > thr_q) ? 1'b0 : 1'b1;
		r_cnt    = count_q[route_p];
		r_full   = (r_cnt >= CNT_W'(arq_rly_pkg::QUEUE_DEPTH));
		r_sum    = SUM_W'(head_q[route_p]) + SUM_W'(r_cnt);
		if (r_sum >= SUM_W'(arq_rly_pkg::QUEUE_DEPTH)) begin
			r_sum = r_sum - SUM_W'(arq_rly_pkg::QUEUE_DEPTH);
		end
		wr_ptr   = r_sum[PTR_W-1:0];
		a_cnt    = count_q[ap_q];
		a_next   = arq_rly_pkg::ptr_inc(head_q[ap_q]);
		is_route = (cmd_q == arq_rly_pkg::CMD_LOCAL) ||
			(cmd_q == arq_rly_pkg::CMD_DATA && !berr_q);
		has_a    = (cmd_q == arq_rly_pkg::CMD_DATA);

		b_now  = 1'b0;
		b_kind = arq_rly_pkg::KIND_DATA;
		b_port = ap_q;
		b_mem  = 1'b0;
		mem_we = 1'b0;
		rd_ptr = head_q[ap_q];
		if (is_route) begin
			b_port = route_p;
			if (r_full) begin
				b_now  = 1'b1;
				b_kind = arq_rly_pkg::KIND_DROP;
			end else begin
				mem_we = 1'b1;
				// new packet is the head: send its own tag
				b_now  = (r_cnt == '0) && !busy_q[route_p];
			end
		end else if (cmd_q == arq_rly_pkg::CMD_ACK) begin
			rd_ptr = a_next;
			b_mem  = 1'b1;
			b_now  = (a_cnt > CNT_W'(1)) && !busy_q[ap_q];
		end else if (cmd_q == arq_rly_pkg::CMD_ERR) begin
			b_mem  = 1'b1;
			b_now  = (a_cnt != '0) && !busy_q[ap_q];
		end
	end

	assign out_free     = !out_valid_q || result.ready;
	assign sts.has_a    = has_a;
	assign sts.b_now    = b_now;
	assign sts.has_b    = has_b_q;
	assign sts.out_free = out_free;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= arq_rly_pkg::cmd_t'(item_cmd);
			ap_q   <= item_arrival_port;
			berr_q <= item_bit_error;
			tag_q  <= item_packet_tag;
			draw_q <= item_random_draw;
			busy_q <= item_channel_busy;
		end
		if (cmd.decide) begin
			b_kind_q <= b_kind;
			b_port_q <= b_port;
			b_mem_q  <= b_mem;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && mem_we) begin
			mem_q[{route_p, wr_ptr}] <= tag_q;
		end
		if (cmd.decide) begin
			rd_data_q <= mem_q[ADDR_W'({ap_q, rd_ptr})];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= arq_rly_pkg::THR_RESET;
			has_b_q <= 1'b0;
			for (int i = 0; i < arq_rly_pkg::NUM_PORTS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (cfg.valid) thr_q <= cfg.data;
			if (cmd.decide) begin
				has_b_q <= b_now;
				if (is_route && !r_full) begin
					count_q[route_p] <= r_cnt + CNT_W'(1);
				end else if (cmd_q == arq_rly_pkg::CMD_ACK && a_cnt != '0) begin
					head_q[ap_q]  <= a_next;
					count_q[ap_q] <= a_cnt - CNT_W'(1);
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_a || cmd.load_b) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_a) begin
			out_kind_q <= berr_q ? arq_rly_pkg::KIND_NAK : arq_rly_pkg::KIND_ACK;
			out_port_q <= ap_q;
			out_tag_q  <= '0;
			out_last_q <= !has_b_q;
		end else if (cmd.load_b) begin
			out_kind_q <= b_kind_q;
			out_port_q <= b_port_q;
			out_tag_q  <= b_mem_q ? rd_data_q : tag_q;
			out_last_q <= 1'b1;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.kind    = out_kind_q;
	assign result.port    = out_port_q;
	assign result.tag_out = out_tag_q;
	assign result.last    = out_last_q;

endmodule

[src/arq_relay_two_port_forwarder_unit.sv]
// Top level of the two-port stop-and-wait relay.
// Depends on arq_rly_pkg, arq_rly_ifs, arq_rly_ctrl and arq_rly_dp.
//
// Usage:
//   item   : one event word per handshake (local packet, neighbor data, ACK, error).
//   result : zero, one or two words per item; last marks the final word of an item.
//   cfg    : writes route_threshold (Q1.16, 65536 = always port 1); always ready.
//            Write only while no item is in flight.
// Timing:
//   An item is taken in the idle state, decided in the next cycle (queue pointer
//   update, queue memory write or registered head read), then its words go out
//   one per cycle through the output register while result.ready stays high. The
//   controller's capture/decide/emit sequence sets this order.
//   A word waits in the output register while result.ready is low; the block
//   holds its next word and accepts no new item until its last word is loaded.
// Reset: arst_n clears queue counts and heads, loads threshold 32768, drops
//   any pending word. Queue memory holds no reset value.
module arq_relay_two_port_forwarder_unit (
	input  logic              clk,
	input  logic              arst_n,
	arq_rly_item_if.sink      item,
	arq_rly_result_if.source  result,
	arq_rly_cfg_if.sink       cfg
);

	arq_rly_pkg::ctl_cmd_t ctl_cmd;
	arq_rly_pkg::ctl_sts_t ctl_sts;
	logic                  item_ready;

	assign item.ready = item_ready;

	arq_rly_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.sts        (ctl_sts),
		.cmd        (ctl_cmd)
	);

	arq_rly_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (ctl_cmd),
		.sts               (ctl_sts),
		.item_cmd          (item.cmd),
		.item_arrival_port (item.arrival_port),
		.item_bit_error    (item.bit_error),
		.item_packet_tag   (item.packet_tag),
		.item_random_draw  (item.random_draw),
		.item_channel_busy (item.channel_busy),
		.cfg               (cfg),
		.result            (result)
	);

endmodule
